/* design/htpa_pkg.sv */
// Shared types, constants and tables for the HT payload airtime block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package htpa_pkg;

  localparam int DUR_W   = 53;
  localparam int SYM_W   = 52;
  localparam int NDBPS_W = 12;
  localparam int DIVR_W  = 13;
  localparam int TSYM_W  = 32;

  localparam logic [4:0]  SERVICE_BITS       = 5'd16;
  localparam logic [10:0] LGI_BITS_PER_CODER = 11'd1280;
  localparam logic [10:0] SGI_BITS_PER_CODER = 11'd1260;

  localparam logic [TSYM_W-1:0] TSYM_LGI_FS = 32'd4000000000;
  localparam logic [TSYM_W-1:0] TSYM_SGI_FS = 32'd3600000000;
  localparam logic [DUR_W-1:0]  SIG_EXT_FS  = 53'd6000000000;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_FIRST  = 2'd1;
  localparam logic [1:0] KIND_MIDDLE = 2'd2;
  localparam logic [1:0] KIND_LAST   = 2'd3;

  typedef struct packed {
    logic [NDBPS_W-1:0] ndbps;
    logic [1:0]         nes;
    logic [TSYM_W-1:0]  tsym;
  } htpa_rate_t;

  // data bits per symbol for one spatial stream
  function automatic logic [9:0] base_dbps(input logic [2:0] modc, input logic wide);
    logic [9:0] v;
    case (modc)
      3'd0:    v = wide ? 10'd54  : 10'd26;
      3'd1:    v = wide ? 10'd108 : 10'd52;
      3'd2:    v = wide ? 10'd162 : 10'd78;
      3'd3:    v = wide ? 10'd216 : 10'd104;
      3'd4:    v = wide ? 10'd324 : 10'd156;
      3'd5:    v = wide ? 10'd432 : 10'd208;
      3'd6:    v = wide ? 10'd486 : 10'd234;
      default: v = wide ? 10'd540 : 10'd260;
    endcase
    return v;
  endfunction

endpackage

/* design/htpa_rate.sv */
// Rate decode: data bits per symbol, BCC encoder count and symbol time.
// Depends on htpa_pkg.
`timescale 1ns / 1ps

module htpa_rate import htpa_pkg::*; (
  input  logic [4:0] mcs,
  input  logic       wide_channel,
  input  logic       short_gi,
  output htpa_rate_t rate
);

  logic [9:0]  base;
  logic [2:0]  streams;
  logic [12:0] prod;
  logic [10:0] per_coder;

  assign base      = base_dbps(mcs[2:0], wide_channel);
  assign streams   = {1'b0, mcs[4:3]} + 3'd1;
  assign prod      = {3'b0, base} * {10'b0, streams};
  assign per_coder = short_gi ? SGI_BITS_PER_CODER : LGI_BITS_PER_CODER;

  always_comb begin
    rate.ndbps = prod[NDBPS_W-1:0];
    // at most 2160 bits per symbol, so one or two encoders
    rate.nes   = (prod[NDBPS_W-1:0] > {1'b0, per_coder}) ? 2'd2 : 2'd1;
    rate.tsym  = short_gi ? TSYM_SGI_FS : TSYM_LGI_FS;
  end

endmodule

/* design/htpa_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on htpa_pkg.
`timescale 1ns / 1ps

module htpa_div import htpa_pkg::*; #(
  parameter int N_W = 57
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [N_W-1:0]    dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [N_W-1:0]    quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic [CW-1:0]     cnt;
  logic              active;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W:0]   trial;
  logic              ge;

  assign trial = {rem, quotient[N_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(N_W);
      end else if (active) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out at the top while quotient bits enter below
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (active) begin
      rem      <= ge ? DIVR_W'(trial - {1'b0, divisor}) : trial[DIVR_W-1:0];
      quotient <= {quotient[N_W-2:0], ge};
    end
  end

endmodule

/* design/htpa_mul.sv */
// Shift-add multiplier by the symbol time, one multiplier bit per cycle,
// with the fixed-point shift and saturation on the result. Depends on htpa_pkg.
`timescale 1ns / 1ps

module htpa_mul import htpa_pkg::*; #(
  parameter int X_W  = 57,
  parameter int FRAC = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [X_W-1:0]    x,
  input  logic [TSYM_W-1:0] tsym,
  output logic              done,
  output logic [DUR_W-1:0]  res
);

  localparam int PW = X_W + TSYM_W;
  localparam int HW = PW - FRAC;

  logic [5:0]        cnt;
  logic              active;
  logic [X_W-1:0]    xr;
  logic [TSYM_W-1:0] m;
  logic [PW-1:0]     acc;
  logic [HW-1:0]     hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= 6'(TSYM_W);
      end else if (active) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // MSB first: double and add; acc holds once finished
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xr  <= x;
      m   <= tsym;
    end else if (active) begin
      acc <= (acc << 1) + (m[TSYM_W-1] ? PW'(xr) : PW'(0));
      m   <= m << 1;
    end
  end

  assign hi  = acc[PW-1:FRAC];
  assign res = (|hi[HW-1:DUR_W]) ? {DUR_W{1'b1}} : hi[DUR_W-1:0];

endmodule

/* design/ht_payload_airtime_core.sv */
// HT payload airtime: one MPDU descriptor in, one duration out.
// A request passes through a set-up state, a radix-2 divide, a fix-up state,
// a shift-add multiply and the output register. One item at a time: the next
// request is taken only after the result loads, and later while the result
// waits. Synchronous reset clears the running totals, the extension register
// and all handshake state.
`timescale 1ns / 1ps

module ht_payload_airtime_core import htpa_pkg::*; #(
  parameter int FRAC_BITS       = 32,
  parameter int AGG_BYTES_WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [4:0]       mcs,
  input  logic             wide_channel,
  input  logic             short_gi,
  input  logic             stbc_on,
  input  logic [15:0]      payload_bytes,
  input  logic [1:0]       mpdu_kind,
  input  logic             accumulate,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic [DUR_W-1:0] duration_fs,
  output logic             negative_clamped
);

  localparam int BW   = AGG_BYTES_WIDTH + 5;
  localparam int XW   = BW + FRAC_BITS;
  localparam int SW   = (XW > SYM_W) ? XW : SYM_W;
  localparam int AIW  = SYM_W - FRAC_BITS;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_FIX  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state, state_next;

  logic                       add_ext;
  logic [AGG_BYTES_WIDTH-1:0] aggregate_bytes;
  logic [SYM_W-1:0]           aggregate_symbols;

  logic [4:0]  mcs_r;
  logic        wide_r, sgi_r, stbc_r, acc_r;
  logic [15:0] bytes_r;
  logic [1:0]  kind_r;
  logic        flag_r;
  logic [XW-1:0] x_r;

  htpa_rate_t rate;
  logic       frag;

  logic [DIVR_W-1:0]          dsym;
  logic [AGG_BYTES_WIDTH:0]   total;
  logic [BW-1:0]              b_last;
  logic [19:0]                b_frag;
  logic [XW-1:0]              dividend;
  logic [DIVR_W-1:0]          divisor;
  logic                       div_start, div_done;
  logic [XW-1:0]              quo;

  logic [XW-1:0]              n_val, need_ext, diff, x_val;
  logic [AIW:0]               need;
  logic [FRAC_BITS-1:0]       af, rf;
  logic                       flag_val;
  logic [SW:0]                sym_sum;
  logic [AGG_BYTES_WIDTH:0]   byte_sum;

  logic                       mul_start, mul_done;
  logic [DUR_W-1:0]           mul_res;
  logic [DUR_W:0]             dur_sum;
  logic                       use_ext;

  htpa_rate u_rate (
    .mcs          (mcs_r),
    .wide_channel (wide_r),
    .short_gi     (sgi_r),
    .rate         (rate)
  );

  assign frag = (kind_r == KIND_FIRST) || (kind_r == KIND_MIDDLE);

  // divide set-up
  always_comb begin
    dsym   = stbc_r ? {rate.ndbps, 1'b0} : {1'b0, rate.ndbps};
    total  = {{(AGG_BYTES_WIDTH+1-16){1'b0}}, bytes_r}
           + ((kind_r == KIND_LAST) ? {1'b0, aggregate_bytes} : '0);
    b_last = BW'(SERVICE_BITS) + BW'({total, 3'b000})
           + (BW'(rate.nes) * BW'(6));
    b_frag = {1'b0, bytes_r, 3'b000}
           + ((kind_r == KIND_FIRST) ? (20'(SERVICE_BITS) + (20'(rate.nes) * 20'd6))
                                     : 20'd0);
    if (frag) begin
      dividend = XW'({b_frag, {FRAC_BITS{1'b0}}});
      divisor  = {1'b0, rate.ndbps};
    end else begin
      // round up to whole symbols
      dividend = XW'(b_last) + XW'(dsym) - XW'(1);
      divisor  = dsym;
    end
  end

  assign div_start = (state == ST_PREP);

  htpa_div #(.N_W(XW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // fix-up: remainder against the running total, multiplier operand
  always_comb begin
    n_val    = stbc_r ? {quo[XW-2:0], 1'b0} : quo;
    af       = aggregate_symbols[FRAC_BITS-1:0];
    rf       = FRAC_BITS'(0) - af;
    need     = {1'b0, aggregate_symbols[SYM_W-1:FRAC_BITS]} + {{AIW{1'b0}}, |af};
    need_ext = XW'(need);
    diff     = n_val - need_ext;
    flag_val = 1'b0;
    case (kind_r)
      KIND_FIRST, KIND_MIDDLE: x_val = quo;
      KIND_SINGLE:             x_val = n_val << FRAC_BITS;
      default: begin
        flag_val = n_val < need_ext;
        x_val    = flag_val ? '0 : ((diff << FRAC_BITS) | XW'(rf));
      end
    endcase
    sym_sum  = (SW+1)'(quo) + (SW+1)'(aggregate_symbols);
    byte_sum = {1'b0, aggregate_bytes} + (AGG_BYTES_WIDTH+1)'(bytes_r);
  end

  assign mul_start = (state == ST_FIX);

  htpa_mul #(.X_W(XW), .FRAC(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (x_val),
    .tsym  (rate.tsym),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign use_ext = add_ext && ((kind_r == KIND_SINGLE) || (kind_r == KIND_LAST));
  assign dur_sum = {1'b0, mul_res} + {1'b0, use_ext ? SIG_EXT_FS : {DUR_W{1'b0}}};

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_FIX;
      ST_FIX:  state_next = ST_MUL;
      ST_MUL:  if (mul_done) state_next = ST_DONE;
      ST_DONE: if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      add_ext           <= 1'b0;
      aggregate_bytes   <= '0;
      aggregate_symbols <= '0;
      rsp_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) add_ext <= cfg_wdata;
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (state == ST_DONE && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      if (state == ST_FIX && acc_r) begin
        if (frag) begin
          aggregate_bytes   <= byte_sum[AGG_BYTES_WIDTH] ? {AGG_BYTES_WIDTH{1'b1}}
                                                         : byte_sum[AGG_BYTES_WIDTH-1:0];
          aggregate_symbols <= (|sym_sum[SW:SYM_W]) ? {SYM_W{1'b1}}
                                                    : sym_sum[SYM_W-1:0];
        end else if (kind_r == KIND_LAST) begin
          aggregate_bytes   <= '0;
          aggregate_symbols <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      mcs_r   <= mcs;
      wide_r  <= wide_channel;
      sgi_r   <= short_gi;
      stbc_r  <= stbc_on;
      bytes_r <= payload_bytes;
      kind_r  <= mpdu_kind;
      acc_r   <= accumulate;
    end
    if (state == ST_FIX) begin
      flag_r <= flag_val;
      x_r    <= x_val;
    end
    if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      duration_fs      <= dur_sum[DUR_W] ? {DUR_W{1'b1}} : dur_sum[DUR_W-1:0];
      negative_clamped <= flag_r && (x_r == '0);
    end
  end

endmodule
